>>> hw/rtl/awp_pkg.sv
// ----------------------------------------------------------------------------
// awp_pkg
// shared types and constants of the affine inverse warp core
// ----------------------------------------------------------------------------
`default_nettype none

package awp_pkg;

   // defaults for the top level parameters
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;
   localparam int FRAC_BITS_DEF  = 16;

   // fixed field widths
   localparam int COEF_W = 32;
   localparam int DIM_W  = 10;
   localparam int POS_W  = 9;
   localparam int CHAN_W = 8;
   localparam int PIX_W  = 3 * CHAN_W;
   localparam int PROD_W = COEF_W + POS_W;     // coef times unsigned position
   localparam int SUM_W  = PROD_W + 3;         // two products plus offset, with margin

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COEF_W;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COEF_XX  = 3'd0,
      REG_COEF_XY  = 3'd1,
      REG_OFFSET_X = 3'd2,
      REG_COEF_YX  = 3'd3,
      REG_COEF_YY  = 3'd4,
      REG_OFFSET_Y = 3'd5,
      REG_WIDTH    = 3'd6,
      REG_HEIGHT   = 3'd7
   } awp_reg_type;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_WARP = 1'b1
   } awp_kind_type;

   typedef struct packed {
      awp_kind_type      kind;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [CHAN_W-1:0] in_blue;
      logic [CHAN_W-1:0] in_green;
      logic [CHAN_W-1:0] in_red;
   } awp_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_red;
      logic              inside_res;
   } awp_rsp_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_xx;
      logic signed [COEF_W-1:0] coef_xy;
      logic signed [COEF_W-1:0] offset_x;
      logic signed [COEF_W-1:0] coef_yx;
      logic signed [COEF_W-1:0] coef_yy;
      logic signed [COEF_W-1:0] offset_y;
      logic [DIM_W-1:0]         frame_width;
      logic [DIM_W-1:0]         frame_height;
   } awp_cfg_type;

   // one classified item on its way from front to back
   typedef struct packed {
      awp_kind_type             kind;
      logic                     store_en;
      logic [POS_W-1:0]         pos_x;
      logic [POS_W-1:0]         pos_y;
      logic [PIX_W-1:0]         pixel;
      logic signed [PROD_W-1:0] prod_xx;
      logic signed [PROD_W-1:0] prod_xy;
      logic signed [PROD_W-1:0] prod_yx;
      logic signed [PROD_W-1:0] prod_yy;
   } awp_entry_type;

   typedef struct packed {
      logic empty;
      logic nearly_full;
      logic full;
   } awp_qstat_type;

endpackage

`default_nettype wire

>>> hw/rtl/awp_front.sv
// ----------------------------------------------------------------------------
// awp_front
// takes items, classifies loads and warps, forms the matrix products
// ----------------------------------------------------------------------------
`default_nettype none

module awp_front #(
   parameter int MAX_WIDTH  = awp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = awp_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire awp_pkg::awp_req_type  req,
   input  wire awp_pkg::awp_cfg_type  cfg,
   output      logic                  push,
   output      awp_pkg::awp_entry_type push_entry
);

   logic                              valid_ff;
   awp_pkg::awp_entry_type            entry_ff;
   awp_pkg::awp_entry_type            entry_in;
   logic signed [awp_pkg::POS_W:0]    x_s;
   logic signed [awp_pkg::POS_W:0]    y_s;
   logic signed [awp_pkg::PROD_W:0]   prod_xx;
   logic signed [awp_pkg::PROD_W:0]   prod_xy;
   logic signed [awp_pkg::PROD_W:0]   prod_yx;
   logic signed [awp_pkg::PROD_W:0]   prod_yy;
   logic                              is_warp;

   assign x_s     = $signed({1'b0, req.pos_x});
   assign y_s     = $signed({1'b0, req.pos_y});
   assign is_warp = (req.kind == awp_pkg::KIND_WARP);

   assign prod_xx = cfg.coef_xx * x_s;
   assign prod_xy = cfg.coef_xy * y_s;
   assign prod_yx = cfg.coef_yx * x_s;
   assign prod_yy = cfg.coef_yy * y_s;

   always_comb begin
      entry_in          = '0;
      entry_in.kind     = req.kind;
      entry_in.pos_x    = req.pos_x;
      entry_in.pos_y    = req.pos_y;
      entry_in.pixel    = {req.in_red, req.in_green, req.in_blue};
      // loads outside the store are dropped
      entry_in.store_en = !is_warp && (32'(req.pos_x) < 32'(MAX_WIDTH))
                          && (32'(req.pos_y) < 32'(MAX_HEIGHT));
      if (is_warp) begin
         entry_in.prod_xx = prod_xx[awp_pkg::PROD_W-1:0];
         entry_in.prod_xy = prod_xy[awp_pkg::PROD_W-1:0];
         entry_in.prod_yx = prod_yx[awp_pkg::PROD_W-1:0];
         entry_in.prod_yy = prod_yy[awp_pkg::PROD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign push       = valid_ff;
   assign push_entry = entry_ff;

endmodule

`default_nettype wire

>>> hw/rtl/awp_queue.sv
// ----------------------------------------------------------------------------
// awp_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module awp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire awp_pkg::awp_entry_type push_entry,
   input  wire logic                   pop,
   output      awp_pkg::awp_entry_type head,
   output      awp_pkg::awp_qstat_type status
);

   awp_pkg::awp_entry_type            entries_ff [awp_pkg::QUEUE_DEPTH];
   logic [awp_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [awp_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [awp_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [awp_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [awp_pkg::QCNT_W-1:0]        count_ff;
   logic [awp_pkg::QCNT_W-1:0]        count_in;
   logic                              do_push;
   logic                              do_pop;

   assign status.empty       = (count_ff == '0);
   assign status.full        = (count_ff == awp_pkg::QCNT_W'(awp_pkg::QUEUE_DEPTH));
   assign status.nearly_full = (count_ff >= awp_pkg::QCNT_W'(awp_pkg::QUEUE_DEPTH - 1));

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/awp_back.sv
// ----------------------------------------------------------------------------
// awp_back
// sums the products, tests the frame, accesses the frame store, gives results
// ----------------------------------------------------------------------------
`default_nettype none

module awp_back #(
   parameter int MAX_WIDTH  = awp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = awp_pkg::MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = awp_pkg::FRAC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire awp_pkg::awp_cfg_type   cfg,
   input  wire awp_pkg::awp_entry_type head,
   input  wire awp_pkg::awp_qstat_type qstat,
   output      logic                   pop,
   output      logic                   rsp_strobe,
   output      awp_pkg::awp_rsp_type   rsp_item
);

   localparam int X_W       = $clog2(MAX_WIDTH);
   localparam int Y_W       = $clog2(MAX_HEIGHT);
   localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int SUM_W     = awp_pkg::SUM_W;

   // sum stage
   logic                            b1_valid_ff;
   awp_pkg::awp_kind_type           b1_kind_ff;
   logic                            b1_store_en_ff;
   logic [awp_pkg::POS_W-1:0]       b1_pos_x_ff;
   logic [awp_pkg::POS_W-1:0]       b1_pos_y_ff;
   logic [awp_pkg::PIX_W-1:0]       b1_pixel_ff;
   logic signed [SUM_W-1:0]         b1_x1_ff;
   logic signed [SUM_W-1:0]         b1_y1_ff;
   logic signed [SUM_W-1:0]         x1_in;
   logic signed [SUM_W-1:0]         y1_in;

   // frame test and store access
   int                              eff_w;
   int                              eff_h;
   logic signed [SUM_W-1:0]         lim_x;
   logic signed [SUM_W-1:0]         lim_y;
   logic                            in_x;
   logic                            in_y;
   logic                            is_warp;
   logic [X_W-1:0]                  col;
   logic [Y_W-1:0]                  row;
   logic [ADDR_W-1:0]               addr;
   logic                            mem_we;

   logic [awp_pkg::PIX_W-1:0]       mem [MEM_DEPTH];
   logic                            b2_valid_ff;
   logic                            b2_inside_ff;
   logic [awp_pkg::PIX_W-1:0]       b2_rdata_ff;

   logic                            rsp_valid_ff;
   awp_pkg::awp_rsp_type            rsp_item_ff;
   awp_pkg::awp_rsp_type            rsp_item_in;

   // the back never holds off, it drains one item each cycle when the queue has one
   assign pop = !qstat.empty;

   assign x1_in = SUM_W'(head.prod_xx) + SUM_W'(head.prod_xy) + SUM_W'(cfg.offset_x);
   assign y1_in = SUM_W'(head.prod_yx) + SUM_W'(head.prod_yy) + SUM_W'(cfg.offset_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b1_kind_ff     <= head.kind;
         b1_store_en_ff <= head.store_en;
         b1_pos_x_ff    <= head.pos_x;
         b1_pos_y_ff    <= head.pos_y;
         b1_pixel_ff    <= head.pixel;
         b1_x1_ff       <= x1_in;
         b1_y1_ff       <= y1_in;
      end
   end

   // frame limits, clipped to the store size
   always_comb begin
      eff_w = (int'(cfg.frame_width) > MAX_WIDTH) ? MAX_WIDTH : int'(cfg.frame_width);
      eff_h = (int'(cfg.frame_height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg.frame_height);
      lim_x = SUM_W'(eff_w - 1) << FRAC_BITS;
      lim_y = SUM_W'(eff_h - 1) << FRAC_BITS;
      in_x  = (eff_w != 0) && !b1_x1_ff[SUM_W-1] && (b1_x1_ff <= lim_x);
      in_y  = (eff_h != 0) && !b1_y1_ff[SUM_W-1] && (b1_y1_ff <= lim_y);
   end

   assign is_warp = (b1_kind_ff == awp_pkg::KIND_WARP);

   always_comb begin
      if (is_warp) begin
         col = b1_x1_ff[FRAC_BITS +: X_W];
         row = b1_y1_ff[FRAC_BITS +: Y_W];
      end else begin
         col = X_W'(b1_pos_x_ff);
         row = Y_W'(b1_pos_y_ff);
      end
      addr = ADDR_W'(32'(row) * 32'(MAX_WIDTH) + 32'(col));
   end

   assign mem_we = b1_valid_ff && !is_warp && b1_store_en_ff;

   // one store access per cycle, loads and warps in item order
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= b1_pixel_ff;
      end else begin
         b2_rdata_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else begin
         b2_valid_ff <= b1_valid_ff && is_warp;
      end
   end

   always_ff @(posedge clock) begin
      b2_inside_ff <= in_x && in_y;
   end

   always_comb begin
      rsp_item_in            = '0;
      rsp_item_in.inside_res = b2_inside_ff;
      if (b2_inside_ff) begin
         rsp_item_in.out_blue  = b2_rdata_ff[awp_pkg::CHAN_W-1:0];
         rsp_item_in.out_green = b2_rdata_ff[awp_pkg::CHAN_W +: awp_pkg::CHAN_W];
         rsp_item_in.out_red   = b2_rdata_ff[2*awp_pkg::CHAN_W +: awp_pkg::CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

`default_nettype wire

>>> hw/rtl/affine_inverse_warp_core.sv
// ----------------------------------------------------------------------------
// affine_inverse_warp_core
// nearest neighbor inverse mapping affine warp over a BGR source frame store
// ----------------------------------------------------------------------------
// the core takes one item per clock: start with busy low. a load item writes
// one pixel of the source frame store and gives no result; a warp item maps
// its destination coordinate through the s15.16 affine matrix and gives one
// result, via the front, queue, sum, store read and result registers, on
// rsp_item for one cycle marked by rsp_strobe. results come in item order and
// cannot be held off, so the receiver must take one every cycle. the sustained
// rate is one item per clock, set by the single port of the frame store, which
// serves one load or one warp read each cycle. busy only rises when the short
// queue between the front and the back nearly fills, which does not happen in
// normal running. the frame store has no reset: read a pixel only after it was
// loaded. write the csr registers only while no warp is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_inverse_warp_core #(
   parameter int MAX_WIDTH  = awp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = awp_pkg::MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = awp_pkg::FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // item side
   input  wire logic                             start,
   output      logic                             busy,
   input  wire awp_pkg::awp_req_type             req_item,
   // result side
   output      logic                             rsp_strobe,
   output      awp_pkg::awp_rsp_type             rsp_item,
   // csr write port
   input  wire logic                             csr_we,
   input  wire logic [awp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [awp_pkg::CSR_DATA_W-1:0]   csr_data
);

   awp_pkg::awp_cfg_type    cfg_ff;
   awp_pkg::awp_cfg_type    cfg_in;
   logic                    accept;
   logic                    push;
   awp_pkg::awp_entry_type  push_entry;
   logic                    pop;
   awp_pkg::awp_entry_type  head;
   awp_pkg::awp_qstat_type  qstat;

   // ---- csr registers ----
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (awp_pkg::awp_reg_type'(csr_index))
            awp_pkg::REG_COEF_XX:  cfg_in.coef_xx      = csr_data;
            awp_pkg::REG_COEF_XY:  cfg_in.coef_xy      = csr_data;
            awp_pkg::REG_OFFSET_X: cfg_in.offset_x     = csr_data;
            awp_pkg::REG_COEF_YX:  cfg_in.coef_yx      = csr_data;
            awp_pkg::REG_COEF_YY:  cfg_in.coef_yy      = csr_data;
            awp_pkg::REG_OFFSET_Y: cfg_in.offset_y     = csr_data;
            awp_pkg::REG_WIDTH:    cfg_in.frame_width  = csr_data[awp_pkg::DIM_W-1:0];
            awp_pkg::REG_HEIGHT:   cfg_in.frame_height = csr_data[awp_pkg::DIM_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // identity matrix and a full-size frame after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_xx      <= 32'sd65536;
         cfg_ff.coef_xy      <= '0;
         cfg_ff.offset_x     <= '0;
         cfg_ff.coef_yx      <= '0;
         cfg_ff.coef_yy      <= 32'sd65536;
         cfg_ff.offset_y     <= '0;
         cfg_ff.frame_width  <= 10'd512;
         cfg_ff.frame_height <= 10'd512;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- item handshake ----
   // hold off when the queue is full, or nearly full with an item in the front
   assign busy   = qstat.full || (qstat.nearly_full && push);
   assign accept = start && !busy;

   // front: classify and multiply
   awp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_item),
      .cfg        (cfg_ff),
      .push       (push),
      .push_entry (push_entry)
   );

   // queue between front and back
   awp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (qstat)
   );

   // back: sum, frame test, store access, result
   awp_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire
